// ===== src/vrt_pkg.sv =====
// shared types and constants for the voxel ray traversal block
// no dependencies
package vrt_pkg;

    // request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_RAY   = 1'b1;

    // widths of the reciprocal dividers and of a cell coordinate
    localparam int DIV_BITS  = 32;
    localparam int MAG_BITS  = 16;
    localparam int CELL_BITS = 6;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_STEP,
        B_LOOK,
        B_DONE
    } t_walk_state;

    // one classified request between front and walker
    typedef struct packed {
        logic                                 is_ray;
        logic [2:0][CELL_BITS-1:0]            vox;
        logic                                 solid;
        logic [2:0][CELL_BITS-1:0]            start;
        logic [2:0]                           neg;
        logic [2:0]                           zero;
        logic [2:0][DIV_BITS-1:0]             delta;
        logic [2:0][DIV_BITS-1:0]             tmax;
    } t_job;

endpackage

// ===== src/vrt_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on vrt_pkg
module vrt_div
    import vrt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_BITS-1:0] i_dividend,
    input  logic [MAG_BITS-1:0] i_divisor,
    output logic                o_busy,
    output logic [DIV_BITS-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_BITS);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIV_BITS-1:0] r_q;
    logic [MAG_BITS-1:0] r_rem;
    logic [MAG_BITS-1:0] r_div;
    logic [MAG_BITS:0]   w_trial;
    logic [MAG_BITS:0]   w_diff;
    logic                w_ge;

    // trial subtraction
    assign w_trial = {r_rem, r_q[DIV_BITS-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_BITS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath: dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_diff[MAG_BITS-1:0] : w_trial[MAG_BITS-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_q;

endmodule

// ===== src/vrt_front.sv =====
// front end: takes requests, classifies them and works out ray set-up
// depends on vrt_pkg and vrt_div
module vrt_front
    import vrt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_enable,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_req_type,
    input  logic [5:0]           i_cell_x,
    input  logic [5:0]           i_cell_y,
    input  logic [5:0]           i_cell_z,
    input  logic                 i_solid,
    input  logic [21:0]          i_origin_x,
    input  logic [21:0]          i_origin_y,
    input  logic [21:0]          i_origin_z,
    input  logic signed [15:0]   i_dir_x,
    input  logic signed [15:0]   i_dir_y,
    input  logic signed [15:0]   i_dir_z,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_job                 o_job
);

    t_front_state r_state, n_state;
    t_job         r_job;
    logic         w_accept;
    logic [2:0]   w_busy, w_tbusy;
    logic [2:0][DIV_BITS-1:0] w_delta_q, w_tmax_q;
    logic [2:0][21:0]         w_org;
    logic [2:0][15:0]         w_dir;

    assign w_org = {i_origin_z, i_origin_y, i_origin_x};
    assign w_dir = {i_dir_z, i_dir_y, i_dir_x};
    assign w_accept = i_valid && o_ready;

    // per-axis reciprocal dividers
    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [15:0]  w_frac;
        logic         w_neg;
        logic [15:0]  w_mag;
        logic [16:0]  w_dist;
        logic [DIV_BITS-1:0] w_num;

        assign w_frac = w_org[a][15:0];
        assign w_neg  = w_dir[a][15];
        assign w_mag  = w_neg ? 16'(-w_dir[a]) : w_dir[a];
        always_comb begin
            if (!w_neg) begin
                w_dist = 17'h10000 - {1'b0, w_frac};
            end else if (w_frac != '0) begin
                w_dist = {1'b0, w_frac};
            end else begin
                w_dist = 17'h10000;
            end
        end
        assign w_num = {w_dist[16:0], 15'd0};

        vrt_div u_delta (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (w_accept && i_req_type == REQ_RAY),
            .i_dividend (DIV_BITS'(1) << (DIV_BITS - 1)),
            .i_divisor  (w_mag),
            .o_busy     (w_busy[a]),
            .o_quotient (w_delta_q[a])
        );

        vrt_div u_tmax (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (w_accept && i_req_type == REQ_RAY),
            .i_dividend (w_num),
            .i_divisor  (w_mag),
            .o_busy     (w_tbusy[a]),
            .o_quotient (w_tmax_q[a])
        );
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job.is_ray <= i_req_type;
            r_job.vox    <= {i_cell_z, i_cell_y, i_cell_x};
            r_job.solid  <= i_solid;
            r_job.start  <= {i_origin_z[21:16], i_origin_y[21:16], i_origin_x[21:16]};
            r_job.neg    <= {i_dir_z[15], i_dir_y[15], i_dir_x[15]};
            r_job.zero   <= {i_dir_z == '0, i_dir_y == '0, i_dir_x == '0};
            r_job.delta  <= '0;
            r_job.tmax   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencing
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                o_ready = i_enable;
                if (w_accept) begin
                    n_state = (i_req_type == REQ_RAY) ? F_DIV : F_PUSH;
                end
            end
            F_DIV: begin
                if ((w_busy | w_tbusy) == '0) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_job       = r_job;
        o_job.delta = w_delta_q;
        o_job.tmax  = w_tmax_q;
    end

endmodule

// ===== src/vrt_queue.sv =====
// two-entry request queue between front end and walker
// depends on vrt_pkg
module vrt_queue
    import vrt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_job   = r_mem[r_rp];
    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;

endmodule

// ===== src/vrt_walk.sv =====
// walker: owns the occupancy memory, applies writes and steps rays
// depends on vrt_pkg
module vrt_walk
    import vrt_pkg::*;
#(
    parameter int SCENE_SIZE   = 64,
    parameter int SCENE_HEIGHT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [5:0] i_ceiling,
    input  logic       i_q_empty,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_cleared,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_hit,
    output logic [5:0] o_hit_x,
    output logic [5:0] o_hit_y,
    output logic [5:0] o_hit_z,
    output logic [1:0] o_face_axis,
    output logic       o_face_negative
);

    localparam int XW    = $clog2(SCENE_SIZE);
    localparam int YW    = $clog2(SCENE_HEIGHT);
    localparam int AW    = 2 * XW + YW;
    localparam int MW    = (XW > YW) ? XW : YW;
    localparam int PW    = ((MW > CELL_BITS) ? MW : CELL_BITS) + 2;
    localparam int LIMIT = 2 * SCENE_SIZE + SCENE_HEIGHT + 3;
    localparam int CW    = $clog2(LIMIT + 1);
    localparam int TW    = DIV_BITS + CW + 1;

    t_walk_state r_state, n_state;

    logic                        mem [2**AW];
    logic                        r_rd;
    logic [AW-1:0]               r_clr_addr;
    logic                        r_cleared;

    logic [2:0][PW-1:0]          r_pos;
    logic [2:0][TW-1:0]          r_tmax;
    logic [2:0][DIV_BITS-1:0]    r_delta;
    logic [2:0]                  r_neg, r_zero;
    logic [CW-1:0]               r_cnt;
    t_axis                       r_axis;

    logic       r_res_hit, r_res_neg;
    logic [5:0] r_res_x, r_res_y, r_res_z;
    t_axis      r_res_axis;

    logic       r_o_valid, r_o_hit, r_o_neg;
    logic [5:0] r_o_x, r_o_y, r_o_z;
    logic [1:0] r_o_axis;

    logic        lt01, lt02, lt12;
    t_axis       w_a;
    logic [2:0][PW-1:0] w_np;
    logic        w_in_scene, w_above, w_limit, w_wr_in;
    logic [AW-1:0] w_raddr, w_waddr;
    logic        w_we, w_wdata, w_finish;
    logic [2:0][PW-1:0] w_vox;

    // axis choice by smallest tmax over moving axes, ties go to the higher-numbered axis
    function automatic logic axis_lt(input logic zi, input logic zj,
                                     input logic [TW-1:0] ti, input logic [TW-1:0] tj);
        return !zi && (zj || ti < tj);
    endfunction

    assign lt01 = axis_lt(r_zero[0], r_zero[1], r_tmax[0], r_tmax[1]);
    assign lt02 = axis_lt(r_zero[0], r_zero[2], r_tmax[0], r_tmax[2]);
    assign lt12 = axis_lt(r_zero[1], r_zero[2], r_tmax[1], r_tmax[2]);

    always_comb begin
        priority if (lt01 && lt02) begin
            w_a = AXIS_X;
        end else if (!lt01 && lt12) begin
            w_a = AXIS_Y;
        end else begin
            w_a = AXIS_Z;
        end
    end

    // stepped position and scene checks
    always_comb begin
        w_np = r_pos;
        w_np[w_a] = r_neg[w_a] ? r_pos[w_a] - PW'(1) : r_pos[w_a] + PW'(1);
    end

    // a step below zero wraps to a large value and fails the upper bound
    assign w_in_scene = w_np[0] < PW'(SCENE_SIZE)
                     && w_np[1] < PW'(SCENE_HEIGHT)
                     && w_np[2] < PW'(SCENE_SIZE);
    assign w_above = (w_a == AXIS_Y) && !r_neg[1]
                     && w_np[1] > {{(PW-6){1'b0}}, i_ceiling};
    assign w_limit = r_cnt == CW'(LIMIT);
    assign w_raddr = {w_np[2][XW-1:0], w_np[1][YW-1:0], w_np[0][XW-1:0]};

    // occupancy write from a request
    for (genvar a = 0; a < 3; a++) begin : g_vox
        assign w_vox[a] = PW'(i_job.vox[a]);
    end
    assign w_wr_in = w_vox[0] < PW'(SCENE_SIZE) && w_vox[1] < PW'(SCENE_HEIGHT)
                  && w_vox[2] < PW'(SCENE_SIZE);

    // memory: clearing pass or request write, one registered read
    always_comb begin
        w_we    = 1'b0;
        w_waddr = {w_vox[2][XW-1:0], w_vox[1][YW-1:0], w_vox[0][XW-1:0]};
        w_wdata = i_job.solid;
        if (r_state == B_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = 1'b0;
        end else if (o_pop && !i_job.is_ray && w_wr_in) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_cleared  <= 1'b0;
        end else if (r_state == B_CLEAR) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == '1) r_cleared <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // walk sequencing
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        w_finish = 1'b0;
        unique case (r_state)
            B_CLEAR: begin
                if (r_clr_addr == '1) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (i_job.is_ray && i_job.zero != 3'b111) n_state = B_STEP;
                    else n_state = B_DONE;
                end
            end
            B_STEP: begin
                if (w_limit || w_above || !w_in_scene) n_state = B_DONE;
                else n_state = B_LOOK;
            end
            B_LOOK: begin
                n_state = r_rd ? B_DONE : B_STEP;
            end
            B_DONE: begin
                if (!r_o_valid || i_ready) begin
                    w_finish = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // ray state and result
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int a = 0; a < 3; a++) begin
                r_pos[a]  <= PW'(i_job.start[a]);
                r_tmax[a] <= TW'(i_job.tmax[a]);
            end
            r_delta    <= i_job.delta;
            r_neg      <= i_job.neg;
            r_zero     <= i_job.zero;
            r_cnt      <= '0;
            r_res_hit  <= 1'b0;
            r_res_x    <= '0;
            r_res_y    <= '0;
            r_res_z    <= '0;
            r_res_axis <= AXIS_X;
            r_res_neg  <= 1'b0;
        end else if (r_state == B_STEP && !w_limit) begin
            r_pos         <= w_np;
            r_tmax[w_a]   <= r_tmax[w_a] + TW'(r_delta[w_a]);
            r_cnt         <= r_cnt + CW'(1);
            r_axis        <= w_a;
        end else if (r_state == B_LOOK && r_rd) begin
            r_res_hit  <= 1'b1;
            r_res_x    <= r_pos[0][5:0];
            r_res_y    <= r_pos[1][5:0];
            r_res_z    <= r_pos[2][5:0];
            r_res_axis <= r_axis;
            r_res_neg  <= !r_neg[r_axis];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_finish) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_o_hit  <= r_res_hit;
            r_o_x    <= r_res_x;
            r_o_y    <= r_res_y;
            r_o_z    <= r_res_z;
            r_o_axis <= r_res_axis;
            r_o_neg  <= r_res_neg;
        end
    end

    assign o_cleared       = r_cleared;
    assign o_valid         = r_o_valid;
    assign o_hit           = r_o_hit;
    assign o_hit_x         = r_o_x;
    assign o_hit_y         = r_o_y;
    assign o_hit_z         = r_o_z;
    assign o_face_axis     = r_o_axis;
    assign o_face_negative = r_o_neg;

endmodule

// ===== src/voxel_ray_traversal.sv =====
// top level of the voxel ray traversal block: ceiling register and the
// front end, request queue and walker; depends on vrt_pkg and all vrt_ modules
//
//  channel   handshake              carries
//  request   i_valid / o_ready      i_req_type, cell, solid, origin, dir
//  result    o_valid / i_ready      o_hit, o_hit_x/y/z, o_face_*
//  config    i_cfg_we               i_cfg_data (ceiling height)
//
// a ray is set up in the reciprocal dividers, then walked voxel by voxel, each
// step followed by a memory read, up to 2*SCENE_SIZE+SCENE_HEIGHT+3 steps. front
// and walker overlap via the queue. after reset a clearing pass over all
// 2**(2*clog2(SCENE_SIZE)+clog2(SCENE_HEIGHT)) memory entries runs before the
// first request is taken.
// a stalled result holds in the output register; the walker then waits.
module voxel_ray_traversal
    import vrt_pkg::*;
#(
    parameter int SCENE_SIZE   = 64,
    parameter int SCENE_HEIGHT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic [5:0]         i_cell_x,
    input  logic [5:0]         i_cell_y,
    input  logic [5:0]         i_cell_z,
    input  logic               i_solid,
    input  logic [21:0]        i_origin_x,
    input  logic [21:0]        i_origin_y,
    input  logic [21:0]        i_origin_z,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_hit,
    output logic [5:0]         o_hit_x,
    output logic [5:0]         o_hit_y,
    output logic [5:0]         o_hit_z,
    output logic [1:0]         o_face_axis,
    output logic               o_face_negative
);

    logic [5:0] r_ceiling;
    logic       w_push, w_pop, w_full, w_empty, w_cleared;
    t_job       w_job_in, w_job_out;

    // ceiling height register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ceiling <= 6'd63;
        end else if (i_cfg_we) begin
            r_ceiling <= i_cfg_data;
        end
    end

    vrt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_enable   (w_cleared),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_cell_x   (i_cell_x),
        .i_cell_y   (i_cell_y),
        .i_cell_z   (i_cell_z),
        .i_solid    (i_solid),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_origin_z (i_origin_z),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_dir_z    (i_dir_z),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    vrt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    vrt_walk #(
        .SCENE_SIZE   (SCENE_SIZE),
        .SCENE_HEIGHT (SCENE_HEIGHT)
    ) u_walk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ceiling       (r_ceiling),
        .i_q_empty       (w_empty),
        .i_job           (w_job_out),
        .o_pop           (w_pop),
        .o_cleared       (w_cleared),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hit           (o_hit),
        .o_hit_x         (o_hit_x),
        .o_hit_y         (o_hit_y),
        .o_hit_z         (o_hit_z),
        .o_face_axis     (o_face_axis),
        .o_face_negative (o_face_negative)
    );

endmodule

// ===== verif/tb_voxel_ray_traversal.sv =====
// self-checking testbench for voxel_ray_traversal: directed table, then random
// scene writes and rays checked against an in-bench DDA walk; depends on vrt_pkg
module tb_voxel_ray_traversal
    import vrt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SZ = 64;
    localparam int HT = 64;
    localparam int WALK_MAX = 2 * SZ + HT + 3;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam logic [63:0] T_INF = '1;

    typedef struct {
        logic              req_type;
        logic [5:0]        cx, cy, cz;
        logic              solid;
        logic [21:0]       ox, oy, oz;
        logic signed [15:0] dx, dy, dz;
    } t_request;

    typedef struct {
        logic       hit;
        logic [5:0] hx, hy, hz;
        t_axis      axis;
        logic       neg;
    } t_outcome;

    typedef struct {
        t_request req;
        logic     typed;
        t_outcome outc;
    } t_row;

    logic i_clk, i_rst_n, i_cfg_we, i_valid, i_ready;
    logic [5:0] i_cfg_data;
    logic o_ready, o_valid;
    logic i_req_type, i_solid;
    logic [5:0] i_cell_x, i_cell_y, i_cell_z;
    logic [21:0] i_origin_x, i_origin_y, i_origin_z;
    logic signed [15:0] i_dir_x, i_dir_y, i_dir_z;
    logic o_hit, o_face_negative;
    logic [5:0] o_hit_x, o_hit_y, o_hit_z;
    logic [1:0] o_face_axis;

    voxel_ray_traversal uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_cell_x(i_cell_x), .i_cell_y(i_cell_y),
        .i_cell_z(i_cell_z), .i_solid(i_solid),
        .i_origin_x(i_origin_x), .i_origin_y(i_origin_y), .i_origin_z(i_origin_z),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_hit(o_hit), .o_hit_x(o_hit_x), .o_hit_y(o_hit_y), .o_hit_z(o_hit_z),
        .o_face_axis(o_face_axis), .o_face_negative(o_face_negative)
    );

    // scene copy and ceiling held by the bench
    bit          scene_occ [SZ*HT*SZ];
    logic [5:0]  ceiling;
    t_outcome    pending_results[$];
    int          mismatches, results_seen, hits_seen, rays_sent, writes_sent;
    longint      cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // walk the ray through the bench's scene, or apply a write
    function automatic t_outcome apply_request(t_request r);
        t_outcome res;
        logic [63:0] tmx[3], dlt[3], org, frac, span, mag;
        int pos[3], stp[3], d, a;
        res = '{hit: 1'b0, hx: '0, hy: '0, hz: '0, axis: AXIS_X, neg: 1'b0};
        if (r.req_type == REQ_WRITE) begin
            scene_occ[(int'(r.cz) * HT + int'(r.cy)) * SZ + int'(r.cx)] = r.solid;
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            org = (i == 0) ? r.ox : (i == 1) ? r.oy : r.oz;
            d = (i == 0) ? r.dx : (i == 1) ? r.dy : r.dz;
            pos[i] = int'(org >> 16);
            frac = org & 64'hFFFF;
            if (d == 0) begin
                stp[i] = 0; dlt[i] = 0; tmx[i] = T_INF;
            end else begin
                mag = (d < 0) ? -d : d;
                stp[i] = (d < 0) ? -1 : 1;
                span = (d > 0) ? 64'd65536 - frac : (frac != 0 ? frac : 64'd65536);
                dlt[i] = (64'd1 << 31) / mag;
                tmx[i] = (span << 15) / mag;
            end
        end
        if (stp[0] == 0 && stp[1] == 0 && stp[2] == 0)
            return res;
        for (int n = 0; n < WALK_MAX; n++) begin
            if (tmx[0] < tmx[1] && tmx[0] < tmx[2]) a = 0;
            else if (!(tmx[0] < tmx[1]) && tmx[1] < tmx[2]) a = 1;
            else a = 2;
            pos[a] += stp[a];
            tmx[a] += dlt[a];
            if (a == 1 && stp[1] > 0 && pos[1] > int'(ceiling)) return res;
            if (pos[0] < 0 || pos[0] >= SZ || pos[1] < 0 || pos[1] >= HT ||
                pos[2] < 0 || pos[2] >= SZ) return res;
            if (scene_occ[(pos[2] * HT + pos[1]) * SZ + pos[0]]) begin
                res.hit = 1'b1;
                res.hx = pos[0][5:0]; res.hy = pos[1][5:0]; res.hz = pos[2][5:0];
                res.axis = t_axis'(a);
                res.neg = stp[a] > 0;
                return res;
            end
        end
        return res;
    endfunction

    // present one request, hold until taken, then maybe leave a gap
    task automatic send_request(t_request r, logic typed, t_outcome given, int gap);
        t_outcome predicted;
        i_valid <= 1'b1;
        i_req_type <= r.req_type;
        i_cell_x <= r.cx; i_cell_y <= r.cy; i_cell_z <= r.cz; i_solid <= r.solid;
        i_origin_x <= r.ox; i_origin_y <= r.oy; i_origin_z <= r.oz;
        i_dir_x <= r.dx; i_dir_y <= r.dy; i_dir_z <= r.dz;
        do @(posedge i_clk); while (!o_ready);
        predicted = apply_request(r);
        pending_results.push_back(typed ? given : predicted);
        if (r.req_type == REQ_RAY) rays_sent++; else writes_sent++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [15:0] rand_dir();
        case ($urandom_range(0, 9))
            0: return 16'sd0;
            1: return -16'sd32768;
            2: return 16'sd32767;
            3: return 16'($urandom_range(0, 15)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // most traffic stays in a small corner so rays meet solid voxels
    function automatic t_request rand_request(bit local_box);
        t_request r;
        int hi;
        hi = local_box ? 15 : 63;
        r.req_type = ($urandom_range(0, 99) < 35) ? REQ_WRITE : REQ_RAY;
        r.cx = 6'($urandom_range(0, hi)); r.cy = 6'($urandom_range(0, hi));
        r.cz = 6'($urandom_range(0, hi));
        r.solid = $urandom_range(0, 9) < 8;
        r.ox = local_box ? 22'($urandom_range(0, 22'h0FFFFF)) : 22'($urandom);
        r.oy = local_box ? 22'($urandom_range(0, 22'h0FFFFF)) : 22'($urandom);
        r.oz = local_box ? 22'($urandom_range(0, 22'h0FFFFF)) : 22'($urandom);
        r.dx = rand_dir(); r.dy = rand_dir(); r.dz = rand_dir();
        return r;
    endfunction

    function automatic t_request ray_req(logic [21:0] ox, oy, oz,
                                         logic signed [15:0] dx, dy, dz);
        return '{req_type: REQ_RAY, cx: 0, cy: 0, cz: 0, solid: 0,
                 ox: ox, oy: oy, oz: oz, dx: dx, dy: dy, dz: dz};
    endfunction

    function automatic t_request wr_req(logic [5:0] x, y, z, logic s);
        return '{req_type: REQ_WRITE, cx: x, cy: y, cz: z, solid: s,
                 ox: 0, oy: 0, oz: 0, dx: 0, dy: 0, dz: 0};
    endfunction

    // wait for the block to drain, then write the ceiling
    task automatic set_ceiling(logic [5:0] v);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ceiling = v;
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else if (cycles % 3000 < 1000) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 3) != 0);
    end

    // result checker
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (o_hit) hits_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("tb: result with nothing pending");
            end else begin
                e = pending_results.pop_front();
                if (o_hit !== e.hit || o_hit_x !== e.hx || o_hit_y !== e.hy ||
                    o_hit_z !== e.hz || o_face_axis !== e.axis ||
                    o_face_negative !== e.neg) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("tb: mismatch exp %0d (%0d,%0d,%0d) ax %0d n %0d",
                                 e.hit, e.hx, e.hy, e.hz, e.axis, e.neg);
                        $display("tb:          got %0d (%0d,%0d,%0d) ax %0d n %0d",
                                 o_hit, o_hit_x, o_hit_y, o_hit_z, o_face_axis,
                                 o_face_negative);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_row rows[$];
        t_outcome none, hx;
        t_request r;
        int burst;
        logic [5:0] ceilings[4];
        cycles = 0; mismatches = 0; results_seen = 0; hits_seen = 0;
        rays_sent = 0; writes_sent = 0;
        ceiling = 6'd63;
        foreach (scene_occ[k]) scene_occ[k] = 1'b0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_data = '0; i_valid = 1'b0;
        i_req_type = REQ_WRITE; i_cell_x = '0; i_cell_y = '0; i_cell_z = '0;
        i_solid = 1'b0; i_origin_x = '0; i_origin_y = '0; i_origin_z = '0;
        i_dir_x = '0; i_dir_y = '0; i_dir_z = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        none = '{hit: 1'b0, hx: '0, hy: '0, hz: '0, axis: AXIS_X, neg: 1'b0};
        hx = '{hit: 1'b1, hx: 6'd5, hy: 6'd5, hz: 6'd5, axis: AXIS_X, neg: 1'b1};
        // directed table: typed rows carry a given answer, the others use the bench's walk
        rows.push_back('{ray_req(22'h58000, 22'h58000, 22'h58000, 0, 0, 0), 1, none});
        rows.push_back('{ray_req(22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF,
                                 32767, 32767, 32767), 1, none});
        rows.push_back('{ray_req(0, 0, 0, -32768, -32768, -32768), 1, none});
        rows.push_back('{wr_req(5, 5, 5, 1), 1, none});
        rows.push_back('{wr_req(63, 63, 63, 1), 1, none});
        rows.push_back('{wr_req(0, 0, 0, 1), 1, none});
        rows.push_back('{ray_req(22'h18000, 22'h58000, 22'h58000, 32767, 0, 0), 1, hx});
        rows.push_back('{ray_req(22'h98000, 22'h58000, 22'h58000, -32768, 0, 0), 0, none});
        rows.push_back('{ray_req(22'h58000, 22'h18000, 22'h58000, 0, 32767, 0), 0, none});
        rows.push_back('{ray_req(22'h58000, 22'h98000, 22'h58000, 0, -1, 0), 0, none});
        rows.push_back('{ray_req(22'h58000, 22'h58000, 22'h18000, 0, 0, 1), 0, none});
        // starting inside a solid voxel does not count
        rows.push_back('{ray_req(22'h58000, 22'h58000, 22'h58000, 0, 0, 32767), 0, none});
        // exact ties on all three axes, and on x/y only
        rows.push_back('{ray_req(22'h20000, 22'h20000, 22'h20000,
                                 16384, 16384, 16384), 0, none});
        rows.push_back('{ray_req(22'h38000, 22'h38000, 22'h50000, 100, 100, 0), 0, none});
        rows.push_back('{ray_req(22'h3F8000, 22'h3F8000, 22'h3F8000,
                                 32767, -32768, 5), 0, none});
        rows.push_back('{ray_req(22'h10000, 22'h10000, 22'h10000, -7, -7, -7), 0, none});
        rows.push_back('{ray_req(22'h3EFFFF, 22'h3EFFFF, 22'h3EFFFF, 1, 1, 1), 0, none});
        rows.push_back('{wr_req(5, 5, 5, 0), 1, none});
        rows.push_back('{ray_req(22'h18000, 22'h58000, 22'h58000, 32767, 0, 0), 1, none});
        foreach (rows[i])
            send_request(rows[i].req, rows[i].typed, rows[i].outc, $urandom_range(0, 2));

        // random phases over several ceiling settings
        ceilings = '{6'd0, 6'd63, 6'($urandom_range(1, 62)), 6'd8};
        for (int ph = 0; ph < 4; ph++) begin
            set_ceiling(ceilings[ph]);
            for (int n = 0; n < 200; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 200; b++, n++) begin
                    r = rand_request($urandom_range(0, 9) < 8);
                    send_request(r, 1'b0, none,
                                 (b == burst - 1) ? $urandom_range(1, 30) : 0);
                end
            end
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        $display("tb: %0d writes and %0d rays over four ceiling settings",
                 writes_sent, rays_sent);
        $display("tb: %0d results checked, %0d hits, %0d mismatches",
                 results_seen, hits_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
